FILE: design/gpa_pkg.sv
// Shared constants and types of the gamepad press autorepeat unit.
`default_nettype none

package gpa_pkg;

	localparam int NUM_BUTTONS = 32;
	localparam int HOLD_WIDTH  = 16;

	localparam int PAD_W     = 32;
	localparam int IDX_W     = 6;
	localparam int HOLD_IN_W = 17;
	localparam int MASK_W    = 32;

	// Magnitude bits of a non-negative hold or period.
	localparam int PER_W  = HOLD_IN_W - 1;
	localparam int BTN_AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int SWP_W  = $clog2(NUM_BUTTONS + 1);
	localparam int CMP_W  = (HOLD_WIDTH > PER_W) ? HOLD_WIDTH : PER_W;
	localparam int STEP_W = $clog2(HOLD_WIDTH + 1);

	localparam logic [HOLD_WIDTH-1:0] CNT_MAX = {HOLD_WIDTH{1'b1}};

	typedef struct packed {
		logic done;
		logic rem_zero;
	} gpa_mod_rsp_t;

endpackage

`default_nettype wire

FILE: design/gpa_cmd_if.sv
// Input channel: frame updates and press queries.
`default_nettype none

interface gpa_cmd_if import gpa_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [PAD_W-1:0]            pad_word;
	logic signed [IDX_W-1:0]     button_index;
	logic signed [HOLD_IN_W-1:0] hold_frames;
	logic signed [HOLD_IN_W-1:0] repeat_period;

	modport source (
		output valid, operation, pad_word, button_index, hold_frames, repeat_period,
		input  ready
	);
	modport sink (
		input  valid, operation, pad_word, button_index, hold_frames, repeat_period,
		output ready
	);
endinterface

`default_nettype wire

FILE: design/gpa_res_if.sv
// Result channel: one pressed mask per query.
`default_nettype none

interface gpa_res_if import gpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] pressed_mask;

	modport source (output valid, pressed_mask, input ready);
	modport sink   (input valid, pressed_mask, output ready);
endinterface

`default_nettype wire

FILE: design/gpa_mod_unit.sv
// Bit-serial remainder unit: hold count modulo repeat period.
`default_nettype none

module gpa_mod_unit import gpa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [HOLD_WIDTH-1:0] dividend,
	input  logic [PER_W-1:0]      divisor,
	output gpa_mod_rsp_t          rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [PER_W-1:0]      rem_q;
	logic [HOLD_WIDTH-1:0] dvd_q;
	logic [PER_W-1:0]      dvs_q;

	logic [PER_W:0] trial;
	logic [PER_W:0] diff;
	logic           ge;

	// One dividend bit enters the partial remainder per cycle.
	assign trial = {rem_q, dvd_q[HOLD_WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(HOLD_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
			dvd_q <= dvd_q << 1;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.rem_zero = (rem_q == '0);

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |-> rem_q < dvs_q)
		else $error("partial remainder reached the divisor");

endmodule

`default_nettype wire

FILE: design/gamepad_press_autorepeat_unit.sv
// Top level: gamepad press detector with hold-to-repeat reporting.
//
//   port  | dir  | word carries
//   ------+------+-------------------------------------------------------------
//   cmd   | sink | operation, pad_word, button_index, hold_frames, repeat_period
//   res   | src  | pressed_mask (one word per query, none per frame update)
//
// A frame update sweeps the 32-entry hold counter memory, one read and one write
// per cycle on its two ports. Queries that need no counter go straight to the
// result stage; a repeat query reads the counter and, once the hold is reached
// and the period is nonzero, runs the bit-serial remainder unit. Reset clears
// both button words and the counter valid bits at once, so no clearing pass is
// needed. A stalled result sits in the output register while frame updates go
// on; a later query waits for it to drain.
`default_nettype none

module gamepad_press_autorepeat_unit import gpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	gpa_cmd_if.sink   cmd,
	gpa_res_if.source res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_QRD   = 3'd2;
	localparam logic [2:0] ST_QMOD  = 3'd3;
	localparam logic [2:0] ST_QFIN  = 3'd4;

	logic [2:0]             state_q;
	logic [NUM_BUTTONS-1:0] cur_q;
	logic [NUM_BUTTONS-1:0] prev_q;
	logic [NUM_BUTTONS-1:0] vld_q;
	logic [SWP_W-1:0]       sw_q;
	logic                   res_valid_q;

	logic [NUM_BUTTONS-1:0] new_q;
	logic [BTN_AW-1:0]      idx_q;
	logic [PER_W-1:0]       hold_q;
	logic [PER_W-1:0]       per_q;
	logic [NUM_BUTTONS-1:0] mask_q;
	logic [MASK_W-1:0]      res_mask_q;

	logic [HOLD_WIDTH-1:0] mem [NUM_BUTTONS];
	logic [HOLD_WIDTH-1:0] mem_rdata_q;
	logic                  mem_re;
	logic                  mem_we;
	logic [BTN_AW-1:0]     mem_raddr;
	logic [BTN_AW-1:0]     mem_waddr;
	logic [HOLD_WIDTH-1:0] mem_wdata;

	logic                   accept;
	logic                   is_frame;
	logic                   idx_neg;
	logic                   idx_big;
	logic                   rpt_off;
	logic [NUM_BUTTONS-1:0] fresh;
	logic [NUM_BUTTONS-1:0] cmd_bit;
	logic [NUM_BUTTONS-1:0] sel_bit;
	logic [SWP_W-1:0]       sw_prev;
	logic [BTN_AW-1:0]      rd_idx;
	logic [HOLD_WIDTH-1:0]  cnt_rd;
	logic                   both;
	logic                   reached;
	logic                   sweep_more;
	logic                   res_free;
	logic                   mod_start;
	gpa_mod_rsp_t           mod_rsp;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign is_frame  = !cmd.operation;
	assign idx_neg   = cmd.button_index[IDX_W-1];
	assign idx_big   = !idx_neg && ($unsigned(cmd.button_index) >= IDX_W'(NUM_BUTTONS));
	assign rpt_off   = cmd.hold_frames[HOLD_IN_W-1] || cmd.repeat_period[HOLD_IN_W-1];

	assign fresh   = ~prev_q & cur_q;
	assign cmd_bit = NUM_BUTTONS'(1) << cmd.button_index[BTN_AW-1:0];
	assign sel_bit = NUM_BUTTONS'(1) << idx_q;

	// The sweep writes entry k-1 while it reads entry k.
	assign sw_prev    = sw_q - SWP_W'(1);
	assign sweep_more = (sw_q < SWP_W'(NUM_BUTTONS));
	assign mem_re     = accept || (state_q == ST_SWEEP && sweep_more);
	assign mem_raddr  = (state_q == ST_SWEEP) ? sw_q[BTN_AW-1:0] :
		(is_frame ? '0 : cmd.button_index[BTN_AW-1:0]);
	assign mem_we     = (state_q == ST_SWEEP);
	assign mem_waddr  = sw_prev[BTN_AW-1:0];

	assign rd_idx = (state_q == ST_SWEEP) ? mem_waddr : idx_q;
	assign cnt_rd = vld_q[rd_idx] ? mem_rdata_q : '0;
	assign both   = prev_q[mem_waddr] & cur_q[mem_waddr];
	assign mem_wdata = !both ? '0 :
		((cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + HOLD_WIDTH'(1));

	assign reached   = CMP_W'(cnt_rd) >= CMP_W'(hold_q);
	assign mod_start = (state_q == ST_QRD) && reached && (per_q != '0);
	assign res_free  = !res_valid_q || res.ready;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	gpa_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (cnt_rd),
		.divisor  (per_q),
		.rsp      (mod_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			prev_q      <= '0;
			vld_q       <= '0;
			sw_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_frame) begin
							sw_q    <= SWP_W'(1);
							state_q <= ST_SWEEP;
						end else if (idx_neg || idx_big || rpt_off) begin
							state_q <= ST_QFIN;
						end else begin
							state_q <= ST_QRD;
						end
					end
				end
				ST_SWEEP: begin
					vld_q[mem_waddr] <= 1'b1;
					sw_q <= sw_q + SWP_W'(1);
					if (!sweep_more) begin
						prev_q  <= cur_q;
						cur_q   <= new_q;
						state_q <= ST_IDLE;
					end
				end
				ST_QRD: begin
					state_q <= mod_start ? ST_QMOD : ST_QFIN;
				end
				ST_QMOD: begin
					if (mod_rsp.done) begin
						state_q <= ST_QFIN;
					end
				end
				ST_QFIN: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A new result word may load in the same cycle the parked one drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_QFIN && res_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_q  <= cmd.pad_word[NUM_BUTTONS-1:0];
			idx_q  <= cmd.button_index[BTN_AW-1:0];
			hold_q <= cmd.hold_frames[PER_W-1:0];
			per_q  <= cmd.repeat_period[PER_W-1:0];
			if (idx_neg) begin
				mask_q <= fresh;
			end else if (idx_big) begin
				mask_q <= '0;
			end else begin
				mask_q <= fresh & cmd_bit;
			end
		end
		// Past the hold, a zero period or a period boundary treats the
		// button as released in the previous frame.
		if (state_q == ST_QRD && !mod_start) begin
			mask_q <= reached ? (cur_q & sel_bit) : (fresh & sel_bit);
		end
		if (state_q == ST_QMOD && mod_rsp.done) begin
			mask_q <= mod_rsp.rem_zero ? (cur_q & sel_bit) : (fresh & sel_bit);
		end
		if (state_q == ST_QFIN && res_free) begin
			res_mask_q <= MASK_W'(mask_q);
		end
	end

	assign res.valid        = res_valid_q;
	assign res.pressed_mask = res_mask_q;

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_waddr != mem_raddr)
		else $error("sweep read and write hit the same counter");

	a_mod_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mod_rsp.done |-> state_q == ST_QMOD)
		else $error("remainder finished outside a repeat query");

	a_words_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP && sweep_more |=> $stable(cur_q) && $stable(prev_q))
		else $error("button words changed during the counter sweep");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted word did not start any work");

endmodule

`default_nettype wire
